### sv/assert_macros.svh
// Assertion macros shared by the RTL files of the value noise unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds on every clock edge out of reset
`define LVNT_ASSERT_ALWAYS(lbl, clk_i, rstn_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define LVNT_ASSERT_IMPLIES(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define LVNT_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define LVNT_ASSERT_ALWAYS(lbl, clk_i, rstn_i, prop)
`define LVNT_ASSERT_IMPLIES(lbl, clk_i, rstn_i, ante, cons)
`define LVNT_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

### sv/lvnt_pkg.sv
// Types and constants shared by the value noise controller, datapath and top level
`default_nettype none

package lvnt_pkg;

  // fixed field widths of the stream payload
  localparam int IDX_FIELD_W   = 8;
  localparam int PERM_W        = 8;
  localparam int LATTICE_W     = 16;
  localparam int COORD_W       = 32;
  localparam int NOISE_W       = 16;
  localparam int IN_TDATA_W    = 128;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 16;

  // selector carried in tuser of the input stream
  typedef enum logic [1:0] {
    ACT_LOAD_PERM  = 2'd0,
    ACT_LOAD_VALUE = 2'd1,
    ACT_SAMPLE     = 2'd2
  } action_t;

  // the seven interpolations: four along x, two along y, one along z
  typedef enum logic [2:0] {
    LERP_X0 = 3'd0,
    LERP_X1 = 3'd1,
    LERP_X2 = 3'd2,
    LERP_X3 = 3'd3,
    LERP_Y0 = 3'd4,
    LERP_Y1 = 3'd5,
    LERP_Z0 = 3'd6
  } lerp_op_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     write_perm;
    logic     write_val;
    logic     capture;
    logic     fetch_valid;
    logic [2:0] fetch_corner;
    logic     lerp_valid;
    lerp_op_t lerp_op;
    logic     load_out;
  } lvnt_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic index_ok;
    logic fetch_busy;
  } lvnt_status_t;

endpackage

`default_nettype wire

### sv/lvnt_ctrl.sv
// Controller: sequences table loads, corner fetches, interpolations and the output register
`default_nettype none

module lvnt_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lvnt_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire lvnt_pkg::lvnt_status_t            status,
  output lvnt_pkg::lvnt_cmd_t                    cmd
);
  import lvnt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LERP,
    ST_FINISH
  } state_t;

  // eight corners issued; the state is held until the last one has passed the fetch pipeline into its corner register
  localparam logic [3:0] FETCH_ISSUE = 4'd8;
  localparam logic [3:0] FETCH_LAST  = 4'd10;
  // z interpolation issued at step 7, written back at step 8
  localparam logic [3:0] LERP_LAST   = 4'd8;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       accept;
  action_t    action;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign accept     = in_tvalid && in_tready;
  assign action     = action_t'(in_tuser);

  // command decode and next state
  always_comb begin
    cmd            = '0;
    cmd.lerp_op    = LERP_X0;
    state_nxt      = state_r;
    step_nxt       = step_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_LOAD_PERM:  cmd.write_perm = status.index_ok;
            ACT_LOAD_VALUE: cmd.write_val  = status.index_ok;
            ACT_SAMPLE: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_FETCH;
              step_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.fetch_valid  = (step_r < FETCH_ISSUE);
        cmd.fetch_corner = step_r[2:0];
        step_nxt         = step_r + 4'd1;
        if (step_r == FETCH_LAST) begin
          state_nxt = ST_LERP;
          step_nxt  = '0;
        end
      end
      ST_LERP: begin
        cmd.lerp_valid = 1'b1;
        case (step_r)
          4'd0: cmd.lerp_op = LERP_X0;
          4'd1: cmd.lerp_op = LERP_X1;
          4'd2: cmd.lerp_op = LERP_X2;
          4'd3: cmd.lerp_op = LERP_X3;
          4'd4: cmd.lerp_op = LERP_Y0;
          4'd5: cmd.lerp_op = LERP_Y1;
          4'd7: cmd.lerp_op = LERP_Z0;
          default: cmd.lerp_valid = 1'b0;
        endcase
        step_nxt = step_r + 4'd1;
        if (step_r == LERP_LAST) begin
          state_nxt = ST_FINISH;
          step_nxt  = '0;
        end
      end
      ST_FINISH: begin
        // wait until the output register is free or being emptied
        if (!out_tvalid_r || out_tready) begin
          cmd.load_out   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/lvnt_datapath.sv
// Datapath: table memories, corner fetch pipeline, shared interpolation unit, result register
`default_nettype none

module lvnt_datapath #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire lvnt_pkg::lvnt_cmd_t                    cmd,
  output lvnt_pkg::lvnt_status_t                      status,
  input  wire logic [lvnt_pkg::IDX_FIELD_W-1:0]       table_index,
  input  wire logic [lvnt_pkg::PERM_W-1:0]            perm_entry,
  input  wire logic signed [lvnt_pkg::LATTICE_W-1:0]  lattice_value,
  input  wire logic signed [lvnt_pkg::COORD_W-1:0]    coord_x,
  input  wire logic signed [lvnt_pkg::COORD_W-1:0]    coord_y,
  input  wire logic signed [lvnt_pkg::COORD_W-1:0]    coord_z,
  output logic signed [lvnt_pkg::NOISE_W-1:0]         noise_value
);
  import lvnt_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int VW     = (VALUE_BITS < LATTICE_W) ? VALUE_BITS : LATTICE_W;
  localparam int PROD_W = VW + FRAC_BITS + 2;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_SIZE - 1);

  // three copies of the permutation table, one per hash level, and the lattice values
  logic [PERM_W-1:0]   perm_a [TABLE_SIZE];
  logic [PERM_W-1:0]   perm_b [TABLE_SIZE];
  logic [PERM_W-1:0]   perm_c [TABLE_SIZE];
  logic signed [VW-1:0] val_mem [TABLE_SIZE];

  // captured sample position
  logic [IDX_W-1:0]     ix_r, iy_r, iz_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fz_r;

  // fetch pipeline
  logic              s1_v_r, s2_v_r, s3_v_r;
  logic [2:0]        s1_c_r, s2_c_r, s3_c_r;
  logic [PERM_W-1:0] p1_r, p2_r, h_r;
  logic [IDX_W-1:0]  addr_a, addr_b, addr_c, addr_v;

  // corner values and interpolation results
  logic signed [VW-1:0] corner_r [8];
  logic signed [VW-1:0] xl_r [4];
  logic signed [VW-1:0] yl_r [2];
  logic signed [VW-1:0] z_r;

  // interpolation unit
  logic signed [VW-1:0]     op_a, op_b;
  logic [FRAC_BITS-1:0]     op_t;
  logic signed [VW:0]       diff;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VW-1:0]     la_r;
  lerp_op_t                 lop_r;
  logic                     lv_r;
  logic signed [PROD_W-1:0] quot;
  logic signed [VW:0]       lsum;

  logic signed [NOISE_W-1:0] out_data_r;
  logic [IDX_W-1:0]          widx;

  assign status.index_ok   = ({1'b0, table_index} < (IDX_FIELD_W + 1)'(TABLE_SIZE));
  assign status.fetch_busy = s1_v_r | s2_v_r | s3_v_r;
  assign widx              = table_index[IDX_W-1:0];
  assign noise_value       = out_data_r;

  // hash addresses: each level after the first adds the previous permutation byte, masked to the table
  assign addr_a = (iz_r + IDX_W'(cmd.fetch_corner[2])) & IDX_MASK;
  assign addr_b = (iy_r + IDX_W'(s1_c_r[1]) + p1_r[IDX_W-1:0]) & IDX_MASK;
  assign addr_c = (ix_r + IDX_W'(s2_c_r[0]) + p2_r[IDX_W-1:0]) & IDX_MASK;
  assign addr_v = h_r[IDX_W-1:0] & IDX_MASK;

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.write_perm) begin
      perm_a[widx] <= perm_entry;
      perm_b[widx] <= perm_entry;
      perm_c[widx] <= perm_entry;
    end
    if (cmd.write_val) begin
      val_mem[widx] <= lattice_value[VW-1:0];
    end
    p1_r <= perm_a[addr_a];
    p2_r <= perm_b[addr_b];
    h_r  <= perm_c[addr_c];
    if (s3_v_r) begin
      corner_r[s3_c_r] <= val_mem[addr_v];
    end
  end

  // sample capture: floored integer parts (low bits only) and fractions
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ix_r <= coord_x[FRAC_BITS +: IDX_W];
      iy_r <= coord_y[FRAC_BITS +: IDX_W];
      iz_r <= coord_z[FRAC_BITS +: IDX_W];
      fx_r <= coord_x[FRAC_BITS-1:0];
      fy_r <= coord_y[FRAC_BITS-1:0];
      fz_r <= coord_z[FRAC_BITS-1:0];
    end
  end

  // corner tags travel with the fetch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.fetch_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
    s1_c_r <= cmd.fetch_corner;
    s2_c_r <= s1_c_r;
    s3_c_r <= s2_c_r;
  end

  // operand select for the issued interpolation
  always_comb begin
    case (cmd.lerp_op)
      LERP_X0: begin op_a = corner_r[0]; op_b = corner_r[1]; op_t = fx_r; end
      LERP_X1: begin op_a = corner_r[2]; op_b = corner_r[3]; op_t = fx_r; end
      LERP_X2: begin op_a = corner_r[4]; op_b = corner_r[5]; op_t = fx_r; end
      LERP_X3: begin op_a = corner_r[6]; op_b = corner_r[7]; op_t = fx_r; end
      LERP_Y0: begin op_a = xl_r[0];     op_b = xl_r[1];     op_t = fy_r; end
      LERP_Y1: begin op_a = xl_r[2];     op_b = xl_r[3];     op_t = fy_r; end
      LERP_Z0: begin op_a = yl_r[0];     op_b = yl_r[1];     op_t = fz_r; end
      default: begin op_a = '0;          op_b = '0;          op_t = '0;   end
    endcase
  end

  assign diff = (VW + 1)'(op_b) - (VW + 1)'(op_a);

  // stage one: (b - a) * t into a register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= 1'b0;
    end else begin
      lv_r <= cmd.lerp_valid;
    end
    prod_r <= PROD_W'(diff) * PROD_W'($signed({1'b0, op_t}));
    la_r   <= op_a;
    lop_r  <= cmd.lerp_op;
  end

  // stage two: floor shift and add; the sum always lies between a and b
  assign quot = prod_r >>> FRAC_BITS;
  assign lsum = (VW + 1)'(la_r) + quot[VW:0];

  always_ff @(posedge clk) begin
    if (lv_r) begin
      case (lop_r)
        LERP_X0: xl_r[0] <= lsum[VW-1:0];
        LERP_X1: xl_r[1] <= lsum[VW-1:0];
        LERP_X2: xl_r[2] <= lsum[VW-1:0];
        LERP_X3: xl_r[3] <= lsum[VW-1:0];
        LERP_Y0: yl_r[0] <= lsum[VW-1:0];
        LERP_Y1: yl_r[1] <= lsum[VW-1:0];
        LERP_Z0: z_r     <= lsum[VW-1:0];
        default: ;
      endcase
    end
  end

  // result register, sign extended to the output field
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= NOISE_W'(z_r);
    end
  end

endmodule

`default_nettype wire

### sv/lattice_value_noise_trilinear_unit.sv
// Top level of the 3D lattice value noise unit with trilinear interpolation
// A sample transfer carries x, y and z in signed fixed point; the unit floors each
// coordinate, hashes the eight cell corners through the permutation table and blends
// their lattice values with seven interpolations into one signed result. Table loads
// produce no output transfer. A sample occupies the unit from its input transfer until
// the result is in the output register: the corners are fetched first (one corner issued
// per cycle through four chained table reads), then the interpolations run on a single
// shared multiplier, and last the output register is loaded, held off for as long as
// the previous result still waits downstream. The next input transfer is taken in the
// cycle after the load, while the result may still wait for the downstream side.
// Entries of both tables hold no defined value until loaded; sampling before loading
// the entries used is undefined.
`default_nettype none

`include "assert_macros.svh"

module lattice_value_noise_trilinear_unit #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // table_index[7:0], perm_entry[15:8], lattice_value[31:16],
  // coord_x[63:32], coord_y[95:64], coord_z[127:96]
  input  wire logic [lvnt_pkg::IN_TDATA_W-1:0]       in_tdata,
  // action[1:0]
  input  wire logic [lvnt_pkg::IN_TUSER_W-1:0]       in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // noise_value[15:0]
  output logic [lvnt_pkg::OUT_TDATA_W-1:0]           out_tdata
);
  import lvnt_pkg::*;

  lvnt_cmd_t                 cmd;
  lvnt_status_t              status;
  logic signed [NOISE_W-1:0] noise_value;

  lvnt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lvnt_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .table_index   (in_tdata[7:0]),
    .perm_entry    (in_tdata[15:8]),
    .lattice_value (in_tdata[31:16]),
    .coord_x       (in_tdata[63:32]),
    .coord_y       (in_tdata[95:64]),
    .coord_z       (in_tdata[127:96]),
    .noise_value   (noise_value)
  );

  assign out_tdata = noise_value;

  // fetch pipeline is empty whenever a new transfer can be taken
  `LVNT_ASSERT_IMPLIES(a_idle_fetch_empty, clk, rst_n, in_tready, !status.fetch_busy)
  // corner fetches and interpolations never overlap
  `LVNT_ASSERT_ALWAYS(a_fetch_lerp_apart, clk, rst_n, !(cmd.fetch_valid && cmd.lerp_valid))
  // loading the result register always presents a transfer next cycle
  `LVNT_ASSERT_NEXT(a_load_shows_valid, clk, rst_n, cmd.load_out, out_tvalid)

endmodule

`default_nettype wire
